// ===== rtl/keyed_event_aggregation_table_top_macros.svh =====
// Assertion macros for the keyed event aggregation table.
// Used by keyed_event_aggregation_table_top.sv; needs clk and rst_n in scope.
`ifndef KEYED_EVENT_AGGREGATION_TABLE_TOP_MACROS_SVH
`define KEYED_EVENT_AGGREGATION_TABLE_TOP_MACROS_SVH
// antecedent in the same cycle
`define KEAT_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("keat assertion failed");
// antecedent in the previous cycle
`define KEAT_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("keat assertion failed");
`endif

// ===== rtl/keat_pkg.sv =====
// Package for the keyed event aggregation table: sizes, entry type, cell commands.
// No dependencies.
`timescale 1ns / 1ps
package keat_pkg;
  localparam int ENTRIES = 64;
  localparam int MAX_OUT = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(MAX_OUT + 1);
  localparam int PID_W   = 23;
  localparam int LIM_W   = 7;

  localparam logic [2:0] OP_NOP = 3'd0;
  localparam logic [2:0] OP_CMP = 3'd1;
  localparam logic [2:0] OP_UPD = 3'd2;
  localparam logic [2:0] OP_INS = 3'd3;
  localparam logic [2:0] OP_SHF = 3'd4;
  localparam logic [2:0] OP_CLR = 3'd5;

  typedef struct packed {
    logic               used;
    logic [63:0]        caller;
    logic signed [63:0] name_low;
    logic signed [63:0] name_high;
    logic [31:0]        hits;
    logic [PID_W-1:0]   pid_min;
    logic [PID_W-1:0]   pid_max;
  } entry_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [63:0]        caller;
    logic signed [63:0] name_low;
    logic signed [63:0] name_high;
    logic [PID_W-1:0]   pid;
  } cmd_t;
endpackage

// ===== rtl/keat_cell.sv =====
// One table cell: holds an entry, compares against the broadcast key, shifts.
// Depends on keat_pkg.
`timescale 1ns / 1ps
module keat_cell import keat_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cmd_t   cmd,
  input  entry_t prev_ent,
  input  logic   prev_lt,
  input  entry_t next_ent,
  output entry_t ent,
  output logic   lt,
  output logic   eq
);
  entry_t ent_r, ent_nxt;
  logic   lt_r, eq_r, less, same;

  // lt: new key sorts before this entry, an empty cell counts as infinity
  always_comb begin
    same = (cmd.caller == ent_r.caller) && (cmd.name_low == ent_r.name_low) &&
           (cmd.name_high == ent_r.name_high);
    less = (cmd.caller < ent_r.caller) ||
           ((cmd.caller == ent_r.caller) && (cmd.name_low < ent_r.name_low)) ||
           ((cmd.caller == ent_r.caller) && (cmd.name_low == ent_r.name_low) &&
            (cmd.name_high < ent_r.name_high));
  end

  always_comb begin
    ent_nxt = ent_r;
    case (cmd.op)
      OP_UPD: begin
        if (eq_r) begin
          if (ent_r.hits != 32'hFFFF_FFFF) ent_nxt.hits = ent_r.hits + 32'd1;
          if (cmd.pid < ent_r.pid_min) ent_nxt.pid_min = cmd.pid;
          else if (cmd.pid > ent_r.pid_max) ent_nxt.pid_max = cmd.pid;
        end
      end
      OP_INS: begin
        if (lt_r && prev_lt) begin
          ent_nxt = prev_ent;
        end else if (lt_r) begin
          ent_nxt.used      = 1'b1;
          ent_nxt.caller    = cmd.caller;
          ent_nxt.name_low  = cmd.name_low;
          ent_nxt.name_high = cmd.name_high;
          ent_nxt.hits      = 32'd1;
          ent_nxt.pid_min   = cmd.pid;
          ent_nxt.pid_max   = cmd.pid;
        end
      end
      OP_SHF: ent_nxt = next_ent;
      OP_CLR: ent_nxt.used = 1'b0;
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.used <= 1'b0;
      lt_r       <= 1'b0;
      eq_r       <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
      if (cmd.op == OP_CMP) begin
        lt_r <= !ent_r.used || less;
        eq_r <= ent_r.used && same;
      end
    end
  end

  assign ent = ent_r;
  assign lt  = lt_r;
  assign eq  = eq_r;
endmodule

// ===== rtl/keat_chain.sv =====
// Row of table cells kept in ascending key order, used cells packed from cell 0.
// Depends on keat_pkg and keat_cell.
`timescale 1ns / 1ps
module keat_chain import keat_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cmd_t   cmd,
  output entry_t head,
  output logic   any_eq,
  output logic   full
);
  entry_t             ents [ENTRIES];
  logic [ENTRIES-1:0] lts, eqs;
  entry_t             empty_ent;

  always_comb begin
    empty_ent      = '0;
    empty_ent.used = 1'b0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    keat_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .prev_ent ((i == 0) ? empty_ent : ents[(i == 0) ? 0 : i-1]),
      .prev_lt  ((i == 0) ? 1'b0 : lts[(i == 0) ? 0 : i-1]),
      .next_ent ((i == ENTRIES-1) ? empty_ent : ents[(i == ENTRIES-1) ? i : i+1]),
      .ent      (ents[i]),
      .lt       (lts[i]),
      .eq       (eqs[i])
    );
  end

  assign head   = ents[0];
  assign any_eq = |eqs;
  assign full   = ents[ENTRIES-1].used;
endmodule

// ===== rtl/keyed_event_aggregation_table_top.sv =====
// Top level of the keyed event aggregation table.
// Depends on keat_pkg, keat_chain (keat_cell) and the assertion macro header.
//
// Use:
//  - in_*: one transaction per event or drain. in_tuser = action (0 insert,
//    1 drain). On an insert, the key is compared in every cell on the accept
//    edge, and the cells update or shift on the next one.
//  - A drain walks the sorted cell row by shifting it towards cell 0, one
//    cell a cycle unless the output stalls.
//    The last qualifying entry is held back one step so tlast can be set.
//  - out_*: results in ascending key order, tlast on the final one. An empty
//    drain gives one transaction with tuser (valid_res) low and tlast high.
//  - Receiver stall: the walk halts while the output register is full and a
//    result waits; none is lost. in_tready stays low until the drain ends.
//  - cfg_*: min_count write, always ready; write only while idle.
//  - Reset (rst_n low, synchronous): table empty, min_count = 1, no output.
//  - Table full on a new key: the event is dropped.
`timescale 1ns / 1ps
`include "keyed_event_aggregation_table_top_macros.svh"
module keyed_event_aggregation_table_top import keat_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // caller[63:0], name_low[127:64], name_high[191:128], pid[214:192],
  // read_limit[221:215], zero pad [223:222]
  input  logic [223:0] in_tdata,
  input  logic         in_tuser,  // action
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_caller[63:0], out_name_low[127:64], out_name_high[191:128],
  // hits[223:192], low_pid[246:224], high_pid[269:247], zero pad [271:270]
  output logic [271:0] out_tdata,
  output logic         out_tuser, // valid_res
  output logic         out_tlast, // last
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data   // min_count
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DRN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [31:0]      min_r;
  cmd_t             cmd, key_r;
  entry_t           head, pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic             any_eq, full;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LIM_W-1:0] lim_r, lim_nxt;
  logic [IDX_W-1:0] walk_r, walk_nxt;
  logic             out_v_r, out_v_nxt, out_last_r, out_last_nxt;
  entry_t           out_r, out_nxt;
  logic             in_acc, out_free, qual, at_limit;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_v_r || out_tready;
  assign qual      = head.used && (head.hits >= min_r);
  assign at_limit  = ({{(LIM_W+1-CNT_W){1'b0}}, cnt_r} == {1'b0, lim_r}) ||
                     (cnt_r == CNT_W'(MAX_OUT));

  always_comb begin
    state_nxt    = state_r;
    cmd          = key_r;
    cmd.op       = OP_NOP;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    cnt_nxt      = cnt_r;
    lim_nxt      = lim_r;
    walk_nxt     = walk_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    out_v_nxt    = out_v_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        cmd.caller    = in_tdata[63:0];
        cmd.name_low  = in_tdata[127:64];
        cmd.name_high = in_tdata[191:128];
        cmd.pid       = in_tdata[214:192];
        if (in_acc && !in_tuser) begin
          cmd.op    = OP_CMP;
          state_nxt = ST_UPD;
        end else if (in_acc) begin
          lim_nxt    = in_tdata[221:215];
          cnt_nxt    = '0;
          walk_nxt   = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_DRN;
        end
      end
      ST_UPD: begin
        if (any_eq) cmd.op = OP_UPD;
        else if (!full) cmd.op = OP_INS;
        state_nxt = ST_IDLE;
      end
      ST_DRN: begin
        if (!head.used || at_limit) begin
          state_nxt = ST_FIN;
        end else if (!(qual && pend_v_r && !out_free)) begin
          if (qual) begin
            if (pend_v_r) begin
              out_nxt      = pend_r;
              out_last_nxt = 1'b0;
              out_v_nxt    = 1'b1;
            end
            pend_nxt   = head;
            pend_v_nxt = 1'b1;
            cnt_nxt    = cnt_r + CNT_W'(1);
          end
          cmd.op   = OP_SHF;
          walk_nxt = walk_r + IDX_W'(1);
          if (walk_r == IDX_W'(ENTRIES - 1)) state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_nxt      = pend_v_r ? pend_r : '0;
          out_nxt.used = pend_v_r;
          out_last_nxt = 1'b1;
          out_v_nxt    = 1'b1;
          pend_v_nxt   = 1'b0;
          cmd.op       = OP_CLR;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      min_r    <= 32'd1;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      cnt_r    <= '0;
      walk_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      cnt_r    <= cnt_nxt;
      walk_r   <= walk_nxt;
      if (cfg_valid && cfg_ready) min_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    lim_r      <= lim_nxt;
    if (state_r == ST_IDLE && in_acc) key_r <= cmd;
  end

  keat_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .head   (head),
    .any_eq (any_eq),
    .full   (full)
  );

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.used;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_r.pid_max, out_r.pid_min, out_r.hits,
                       out_r.name_high, out_r.name_low, out_r.caller};

  // nothing held back once the drain is over
  `KEAT_ASSERT_IMP(a_idle_no_pend, state_r == ST_IDLE, !pend_v_r)
  // an insert always resolves in the following cycle
  `KEAT_ASSERT_NXT(a_ins_upd, in_acc && !in_tuser, state_r == ST_UPD)
  // an empty-drain item never carries an entry flag and always closes the drain
  `KEAT_ASSERT_IMP(a_empty_last, out_tvalid && !out_tuser, out_tlast)
  // count of emitted entries never passes the drain limit
  `KEAT_ASSERT_IMP(a_cnt_lim, state_r == ST_DRN,
                   {{(LIM_W+1-CNT_W){1'b0}}, cnt_r} <= {1'b0, lim_r})
endmodule
